// ===== rtl/pkes_pkg.sv =====
// Shared types, constants and register codes of the pad key event scanner.
package pkes_pkg;

  localparam int unsigned ButtonSlots = 16;
  localparam int unsigned PadBits     = 16;
  localparam int unsigned ScanSlots   = (ButtonSlots < PadBits) ? ButtonSlots : PadBits;
  localparam int unsigned IdxW        = $clog2(PadBits);

  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgDataW = 64;

  localparam logic [2:0] RegKeymapLow  = 3'd0;
  localparam logic [2:0] RegKeymapHigh = 3'd1;
  localparam logic [2:0] RegPrimary    = 3'd2;
  localparam logic [2:0] RegConfirm    = 3'd3;
  localparam logic [2:0] RegPoll       = 3'd4;
  localparam logic [2:0] RegReprobe    = 3'd5;
  localparam logic [2:0] RegFailLimit  = 3'd6;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindMain = 2'd1;
  localparam logic [1:0] KindAlt  = 2'd2;

  localparam logic [31:0] LastPollReset = 32'hFFFF_FC18;
  localparam logic [7:0]  FailSat       = 8'hFF;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  local_levels;
    logic        menu_active;
    logic        alt_probe_ok;
    logic        alt_init_ok;
    logic        main_init_ok;
    logic        read_ok;
    logic [15:0] read_bits;
  } in_word_t;

  typedef struct packed {
    logic       is_key_event;
    logic       key_down;
    logic [7:0] key_code;
    logic       fps_overlay;
    logic       music_enable;
    logic [1:0] controller_kind;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [63:0] keymap_low;
    logic [63:0] keymap_high;
    logic [3:0]  primary_slot;
    logic [3:0]  confirm_slot;
    logic [15:0] poll_interval;
    logic [15:0] reprobe_delay;
    logic [7:0]  failure_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
    logic [15:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        reached;
  } alu_rsp_t;

endpackage

// ===== rtl/pkes_cfg.sv =====
// Configuration register file behind the APB-style port.
module pkes_cfg import pkes_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CfgAddrW-1:3];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keymap_low    <= '0;
      cfg_q.keymap_high   <= '0;
      cfg_q.primary_slot  <= 4'd0;
      cfg_q.confirm_slot  <= 4'd1;
      cfg_q.poll_interval <= 16'd8;
      cfg_q.reprobe_delay <= 16'd1000;
      cfg_q.failure_limit <= 8'd2;
    end else if (wr_en) begin
      case (reg_idx)
        RegKeymapLow:  cfg_q.keymap_low    <= pwdata;
        RegKeymapHigh: cfg_q.keymap_high   <= pwdata;
        RegPrimary:    cfg_q.primary_slot  <= pwdata[3:0];
        RegConfirm:    cfg_q.confirm_slot  <= pwdata[3:0];
        RegPoll:       cfg_q.poll_interval <= pwdata[15:0];
        RegReprobe:    cfg_q.reprobe_delay <= pwdata[15:0];
        RegFailLimit:  cfg_q.failure_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKeymapLow:  prdata = cfg_q.keymap_low;
      RegKeymapHigh: prdata = cfg_q.keymap_high;
      RegPrimary:    prdata = {60'd0, cfg_q.primary_slot};
      RegConfirm:    prdata = {60'd0, cfg_q.confirm_slot};
      RegPoll:       prdata = {48'd0, cfg_q.poll_interval};
      RegReprobe:    prdata = {48'd0, cfg_q.reprobe_delay};
      RegFailLimit:  prdata = {56'd0, cfg_q.failure_limit};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/pkes_alu.sv =====
// Shared 32-bit add/subtract unit with signed-interval threshold compare.
module pkes_alu import pkes_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [31:0] sum;

  assign sum = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);

  assign rsp_o.res     = sum;
  assign rsp_o.reached = ~sum[31] & ((|sum[30:16]) | (sum[15:0] >= req_i.lim));

endmodule

// ===== rtl/pkes_seq.sv =====
// Tick sequencer: button state, controller probe and poll, event scan and output word.
module pkes_seq import pkes_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOCAL   = 4'd1;
  localparam logic [3:0] S_PROBE   = 4'd2;
  localparam logic [3:0] S_FOUND   = 4'd3;
  localparam logic [3:0] S_REPROBE = 4'd4;
  localparam logic [3:0] S_POLL    = 4'd5;
  localparam logic [3:0] S_MENU    = 4'd6;
  localparam logic [3:0] S_SCAN    = 4'd7;
  localparam logic [3:0] S_STATUS  = 4'd8;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(ScanSlots - 1);

  logic [3:0]         state_q, state_d;
  in_word_t           in_q, in_d;
  logic [1:0]         kind_q, kind_d;
  logic [7:0]         fail_q, fail_d;
  logic [PadBits-1:0] cached_q, cached_d;
  logic [31:0]        next_probe_q, next_probe_d;
  logic [31:0]        last_poll_q, last_poll_d;
  logic [PadBits-1:0] prev_pad_q, prev_pad_d;
  logic [1:0]         prev_local_q, prev_local_d;
  logic               overlay_q, overlay_d;
  logic               music_q, music_d;
  logic [PadBits-1:0] cur_q, cur_d;
  logic [PadBits-1:0] changed_q, changed_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic               can_load;
  logic               accept;
  logic [1:0]         pressed;
  logic [7:0]         fail_inc;
  logic [PadBits-1:0] cur_menu;
  logic [127:0]       keymap;
  logic [7:0]         code;
  logic               emit;

  pkes_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i & ~in_stall_o;
  assign can_load    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign pressed  = ~in_q.local_levels;
  assign fail_inc = (fail_q == FailSat) ? fail_q : fail_q + 8'd1;
  assign keymap   = {cfg_i.keymap_high, cfg_i.keymap_low};
  assign code     = keymap[{idx_q, 3'b000} +: 8];
  assign emit     = changed_q[idx_q] & (code != 8'd0);

  always_comb begin
    cur_menu = cur_q;
    if (in_q.menu_active && cur_q[cfg_i.primary_slot]) begin
      cur_menu[cfg_i.primary_slot] = 1'b0;
      cur_menu[cfg_i.confirm_slot] = 1'b1;
    end
  end

  always_comb begin
    alu_req.a   = in_q.now_ms;
    alu_req.b   = next_probe_q;
    alu_req.sub = 1'b1;
    alu_req.lim = '0;
    case (state_q)
      S_FOUND: begin
        alu_req.b = {16'd0, cfg_i.poll_interval};
      end
      S_REPROBE: begin
        alu_req.b   = {16'd0, cfg_i.reprobe_delay};
        alu_req.sub = 1'b0;
      end
      S_POLL: begin
        alu_req.b   = last_poll_q;
        alu_req.lim = cfg_i.poll_interval;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    in_d         = in_q;
    kind_d       = kind_q;
    fail_d       = fail_q;
    cached_d     = cached_q;
    next_probe_d = next_probe_q;
    last_poll_d  = last_poll_q;
    prev_pad_d   = prev_pad_q;
    prev_local_d = prev_local_q;
    overlay_d    = overlay_q;
    music_d      = music_q;
    cur_d        = cur_q;
    changed_d    = changed_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_d        = out_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          in_d    = in_word_i;
          state_d = S_LOCAL;
        end
      end
      S_LOCAL: begin
        if (pressed[0] && !prev_local_q[0]) overlay_d = ~overlay_q;
        if (pressed[1] && !prev_local_q[1]) music_d = ~music_q;
        prev_local_d = pressed;
        state_d      = (kind_q == KindNone) ? S_PROBE : S_POLL;
      end
      S_PROBE: begin
        state_d = S_POLL;
        if (alu_rsp.reached) begin
          if (in_q.alt_probe_ok) begin
            if (in_q.alt_init_ok) begin
              kind_d  = KindAlt;
              fail_d  = '0;
              state_d = S_FOUND;
            end else begin
              state_d = S_REPROBE;
            end
          end else if (in_q.main_init_ok) begin
            kind_d  = KindMain;
            fail_d  = '0;
            state_d = S_FOUND;
          end else begin
            state_d = S_REPROBE;
          end
        end
      end
      S_FOUND: begin
        last_poll_d = alu_rsp.res;
        state_d     = S_POLL;
      end
      S_REPROBE: begin
        next_probe_d = alu_rsp.res;
        state_d      = S_POLL;
      end
      S_POLL: begin
        state_d = S_MENU;
        cur_d   = cached_q;
        if (kind_q == KindNone) begin
          cur_d = '0;
        end else if (alu_rsp.reached) begin
          last_poll_d = in_q.now_ms;
          if (in_q.read_ok) begin
            cur_d    = in_q.read_bits;
            cached_d = in_q.read_bits;
            fail_d   = '0;
          end else begin
            cur_d    = '0;
            cached_d = '0;
            fail_d   = fail_inc;
            if (fail_inc >= cfg_i.failure_limit) begin
              kind_d  = KindNone;
              fail_d  = '0;
              state_d = S_REPROBE;
            end
          end
        end
      end
      S_MENU: begin
        cur_d      = cur_menu;
        changed_d  = cur_menu ^ prev_pad_q;
        prev_pad_d = cur_menu;
        idx_d      = '0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (!emit || can_load) begin
          if (emit) begin
            out_valid_d           = 1'b1;
            out_d.is_key_event    = 1'b1;
            out_d.key_down        = cur_q[idx_q];
            out_d.key_code        = code;
            out_d.fps_overlay     = overlay_q;
            out_d.music_enable    = music_q;
            out_d.controller_kind = kind_q;
            out_d.last            = 1'b0;
          end
          idx_d = idx_q + 1'b1;
          if (idx_q == LastIdx) state_d = S_STATUS;
        end
      end
      S_STATUS: begin
        if (can_load) begin
          out_valid_d           = 1'b1;
          out_d.is_key_event    = 1'b0;
          out_d.key_down        = 1'b0;
          out_d.key_code        = '0;
          out_d.fps_overlay     = overlay_q;
          out_d.music_enable    = music_q;
          out_d.controller_kind = kind_q;
          out_d.last            = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= KindNone;
      fail_q       <= '0;
      cached_q     <= '0;
      next_probe_q <= '0;
      last_poll_q  <= LastPollReset;
      prev_pad_q   <= '0;
      prev_local_q <= '0;
      overlay_q    <= 1'b0;
      music_q      <= 1'b1;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      fail_q       <= fail_d;
      cached_q     <= cached_d;
      next_probe_q <= next_probe_d;
      last_poll_q  <= last_poll_d;
      prev_pad_q   <= prev_pad_d;
      prev_local_q <= prev_local_d;
      overlay_q    <= overlay_d;
      music_q      <= music_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    cur_q     <= cur_d;
    changed_q <= changed_d;
    out_q     <= out_d;
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("accepted word did not start the sequencer");

  a_no_ctrl_no_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == KindNone) |-> (fail_q == 8'd0))
    else $error("failure count held without a controller");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q != 2'd3)
    else $error("controller kind holds an unused code");

  a_status_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STATUS && state_d == S_IDLE) |=> (out_valid_q && out_q.last))
    else $error("tick closed without a status word");

  a_event_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_key_event) |-> !out_q.last)
    else $error("key event word marked last");

endmodule

// ===== rtl/pad_key_event_scanner.sv =====
// Top level of the pad key event scanner: register file and tick sequencer.
//
// One input word per tick carries the time, local button levels, menu flag
// and the controller probe/init/read answers. Each tick yields zero to
// sixteen key event words, lowest button slot first, then one status word
// with last set. Both channels use valid/stall; a word moves on a rising
// edge with valid high and stall low.
// An accepted word steps through the sequencer states, which share the
// 32-bit add/compare unit (local buttons, probe, found or reprobe, poll, a
// reprobe and second poll when a controller drops, menu remap), then the
// scan, one button slot per cycle while the output does not stall, then
// the status word. in_stall_o stays high for the whole tick and drops once
// the status word is loaded, so no new word is accepted during a tick.
// Results pass through one output register; a stall on the output holds
// that word and pauses the scan at the next key event until it is taken.
// The next input word is accepted while the status word still waits.
// Reset clears the controller state, sets music on and the overlay off,
// and loads the register defaults. Write registers over the APB-style
// port only while no tick is in progress.
module pad_key_event_scanner import pkes_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o
);

  cfg_t cfg;

  pkes_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pkes_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
